// ----- rtl/rational_arithmetic_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RAU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rational arithmetic unit: check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define RAU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rational arithmetic unit: check failed");

`endif

// ----- rtl/rau_pkg.sv -----
package rau_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int FIELD_WIDTH = 16;
   localparam int PROD_WIDTH  = VALUE_WIDTH + FIELD_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 1;
   localparam int COUNT_WIDTH = $clog2(SUM_WIDTH + 1);
   localparam int PROD_COUNT  = 4;
   localparam int STEP_WIDTH  = $clog2(PROD_COUNT);

   typedef enum logic [2:0] {
      ACT_LOAD = 3'd0,
      ACT_ADD  = 3'd1,
      ACT_SUB  = 3'd2,
      ACT_MUL  = 3'd3,
      ACT_DIV  = 3'd4,
      ACT_CMP  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_ZERO_DEN = 2'd1,
      STAT_DIV_ZERO = 2'd2,
      STAT_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_COMB,
      ST_MAG,
      ST_GCD,
      ST_DIV_NUM_GO,
      ST_DIV_NUM,
      ST_DIV_DEN_GO,
      ST_DIV_DEN,
      ST_FIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef logic signed [SUM_WIDTH-1:0] wide_type;
   typedef logic        [SUM_WIDTH-1:0] mag_type;

   function automatic wide_type widen_field(input logic signed [FIELD_WIDTH-1:0] v);
      return wide_type'({{(SUM_WIDTH-FIELD_WIDTH){v[FIELD_WIDTH-1]}}, v});
   endfunction

   function automatic wide_type widen_value(input logic signed [VALUE_WIDTH-1:0] v);
      return wide_type'({{(SUM_WIDTH-VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v});
   endfunction

   function automatic wide_type widen_prod(input logic signed [PROD_WIDTH-1:0] v);
      return wide_type'({{(SUM_WIDTH-PROD_WIDTH){v[PROD_WIDTH-1]}}, v});
   endfunction

   function automatic logic fits_value(input wide_type v);
      return v == widen_value(v[VALUE_WIDTH-1:0]);
   endfunction

   function automatic mag_type magnitude(input wide_type v);
      return v[SUM_WIDTH-1] ? mag_type'(-v) : mag_type'(v);
   endfunction

endpackage

// ----- rtl/rational_arithmetic_unit.sv -----
// Rational accumulator: each transaction loads, adds, subtracts, multiplies, divides or
// compares the stored fraction against the operand fraction, and returns one result with
// the accumulator after the step. Rejected transactions, unknown actions and loads go
// straight from accept to result; compare forms its cross products on the one shared
// multiplier and compares them. Arithmetic uses the same multiplier, a binary GCD that
// does one shift, or one subtract and shift, per cycle, and two restoring divisions by
// the GCD on one shared divider. A zero result numerator skips the GCD and the divisions.
// No new transaction is taken until the result has been taken.
module rational_arithmetic_unit import rau_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_action,
   input  logic signed [FIELD_WIDTH-1:0] req_operand_num,
   input  logic signed [FIELD_WIDTH-1:0] req_operand_den,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [FIELD_WIDTH-1:0] rsp_result_num,
   output logic signed [FIELD_WIDTH-1:0] rsp_result_den,
   output logic                          rsp_equal_flag,
   output logic [1:0]                    rsp_status
);

   state_type                     state_ff, state_in;
   logic [STEP_WIDTH-1:0]         step_ff, step_in;
   action_type                    action_ff, action_in;
   logic signed [FIELD_WIDTH-1:0] op_num_ff, op_num_in;
   logic signed [FIELD_WIDTH-1:0] op_den_ff, op_den_in;
   logic signed [VALUE_WIDTH-1:0] acc_num_ff, acc_num_in;
   logic signed [VALUE_WIDTH-1:0] acc_den_ff, acc_den_in;
   wide_type                      n_ff, n_in;
   wide_type                      d_ff, d_in;
   mag_type                       ga_ff, ga_in;
   mag_type                       gb_ff, gb_in;
   logic [COUNT_WIDTH-1:0]        k_ff, k_in;
   mag_type                       g_ff, g_in;
   mag_type                       qn_ff, qn_in;
   mag_type                       qd_ff, qd_in;
   logic                          eq_ff, eq_in;
   status_type                    status_ff, status_in;

   logic signed [PROD_WIDTH-1:0]  prod_ff [PROD_COUNT];
   logic signed [VALUE_WIDTH-1:0] mult_a;
   logic signed [FIELD_WIDTH-1:0] mult_b;
   logic signed [PROD_WIDTH-1:0]  mult_p;

   logic                          div_start;
   mag_type                       div_dividend;
   mag_type                       div_quotient;
   div_status_type                div_stat;

   wide_type                      vn, vd;
   wide_type                      acc_num_wide, acc_den_wide;
   wide_type                      load_num, load_den;

   assign mult_a = step_ff[0] ? acc_den_ff : acc_num_ff;
   assign mult_b = (step_ff[0] ^ step_ff[1]) ? op_num_ff : op_den_ff;
   assign mult_p = mult_a * mult_b;

   assign load_num = widen_field(req_operand_num);
   assign load_den = widen_field(req_operand_den);

   rau_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .quotient (div_quotient),
      .status   (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      action_in    = action_ff;
      op_num_in    = op_num_ff;
      op_den_in    = op_den_ff;
      acc_num_in   = acc_num_ff;
      acc_den_in   = acc_den_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      qn_in        = qn_ff;
      qd_in        = qd_ff;
      eq_in        = eq_ff;
      status_in    = status_ff;
      div_start    = 1'b0;
      div_dividend = magnitude((state_ff == ST_DIV_NUM_GO) ? n_ff : d_ff);
      vn           = n_ff[SUM_WIDTH-1] ? -wide_type'(qn_ff) : wide_type'(qn_ff);
      vd           = d_ff[SUM_WIDTH-1] ? -wide_type'(qd_ff) : wide_type'(qd_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in = action_type'(req_action);
               op_num_in = req_operand_num;
               op_den_in = req_operand_den;
               eq_in     = 1'b0;
               status_in = STAT_OK;
               step_in   = '0;
               state_in  = ST_DONE;
               priority if (req_action > ACT_CMP) begin
                  status_in = STAT_OK;
               end else if (req_operand_den == '0) begin
                  status_in = STAT_ZERO_DEN;
               end else if (req_action == ACT_DIV && req_operand_num == '0) begin
                  status_in = STAT_DIV_ZERO;
               end else if (req_action == ACT_LOAD) begin
                  if (fits_value(load_num) && fits_value(load_den)) begin
                     acc_num_in = load_num[VALUE_WIDTH-1:0];
                     acc_den_in = load_den[VALUE_WIDTH-1:0];
                  end else begin
                     status_in = STAT_OVERFLOW;
                  end
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            step_in = step_ff + STEP_WIDTH'(1);
            if (step_ff == STEP_WIDTH'(PROD_COUNT - 1)) begin
               state_in = ST_COMB;
            end
         end
         ST_COMB: begin
            state_in = ST_MAG;
            unique case (action_ff)
               ACT_ADD: begin
                  n_in = widen_prod(prod_ff[0]) + widen_prod(prod_ff[1]);
                  d_in = widen_prod(prod_ff[3]);
               end
               ACT_SUB: begin
                  n_in = widen_prod(prod_ff[0]) - widen_prod(prod_ff[1]);
                  d_in = widen_prod(prod_ff[3]);
               end
               ACT_MUL: begin
                  n_in = widen_prod(prod_ff[2]);
                  d_in = widen_prod(prod_ff[3]);
               end
               ACT_DIV: begin
                  n_in = widen_prod(prod_ff[0]);
                  d_in = widen_prod(prod_ff[1]);
               end
               ACT_CMP: begin
                  eq_in    = (prod_ff[0] == prod_ff[1]);
                  state_in = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_MAG: begin
            if (n_ff == '0) begin
               qn_in    = '0;
               qd_in    = magnitude(d_ff);
               state_in = ST_FIT;
            end else begin
               ga_in    = magnitude(n_ff);
               gb_in    = magnitude(d_ff);
               k_in     = '0;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            priority if (ga_ff == gb_ff) begin
               g_in     = ga_ff << k_ff;
               state_in = ST_DIV_NUM_GO;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               k_in  = k_ff + COUNT_WIDTH'(1);
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff > gb_ff) begin
               ga_in = (ga_ff - gb_ff) >> 1;
            end else begin
               gb_in = (gb_ff - ga_ff) >> 1;
            end
         end
         ST_DIV_NUM_GO: begin
            if (!div_stat.busy) begin
               div_start = 1'b1;
               state_in  = ST_DIV_NUM;
            end
         end
         ST_DIV_NUM: begin
            if (div_stat.done) begin
               qn_in    = div_quotient;
               state_in = ST_DIV_DEN_GO;
            end
         end
         ST_DIV_DEN_GO: begin
            if (!div_stat.busy) begin
               div_start = 1'b1;
               state_in  = ST_DIV_DEN;
            end
         end
         ST_DIV_DEN: begin
            if (div_stat.done) begin
               qd_in    = div_quotient;
               state_in = ST_FIT;
            end
         end
         ST_FIT: begin
            if (fits_value(vn) && fits_value(vd)) begin
               acc_num_in = vn[VALUE_WIDTH-1:0];
               acc_den_in = vd[VALUE_WIDTH-1:0];
               status_in  = STAT_OK;
            end else begin
               status_in  = STAT_OVERFLOW;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         acc_num_ff <= '0;
         acc_den_ff <= VALUE_WIDTH'(1);
      end else begin
         state_ff   <= state_in;
         acc_num_ff <= acc_num_in;
         acc_den_ff <= acc_den_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      action_ff <= action_in;
      op_num_ff <= op_num_in;
      op_den_ff <= op_den_in;
      n_ff      <= n_in;
      d_ff      <= d_in;
      ga_ff     <= ga_in;
      gb_ff     <= gb_in;
      k_ff      <= k_in;
      g_ff      <= g_in;
      qn_ff     <= qn_in;
      qd_ff     <= qd_in;
      eq_ff     <= eq_in;
      status_ff <= status_in;
      if (state_ff == ST_MUL) begin
         prod_ff[step_ff] <= mult_p;
      end
   end

   assign acc_num_wide   = widen_value(acc_num_ff);
   assign acc_den_wide   = widen_value(acc_den_ff);
   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_result_num = acc_num_wide[FIELD_WIDTH-1:0];
   assign rsp_result_den = acc_den_wide[FIELD_WIDTH-1:0];
   assign rsp_equal_flag = eq_ff;
   assign rsp_status     = status_ff;

endmodule

// ----- rtl/rau_divider.sv -----
module rau_divider import rau_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  mag_type        dividend,
   input  mag_type        divisor,
   output mag_type        quotient,
   output div_status_type status
);

   logic [SUM_WIDTH:0]     rem_ff, rem_in;
   mag_type                quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [SUM_WIDTH:0]     shifted;

   always_comb begin
      shifted  = {rem_ff[SUM_WIDTH-1:0], quo_ff[SUM_WIDTH-1]};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         count_in = COUNT_WIDTH'(SUM_WIDTH);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = shifted - {1'b0, divisor};
            quo_in = {quo_ff[SUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[SUM_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - COUNT_WIDTH'(1);
         if (count_ff == COUNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      count_ff <= count_in;
   end

   assign quotient = quo_ff;
   assign status   = '{busy: busy_ff, done: done_ff};

endmodule

// ----- rtl/rau_checker.sv -----
`include "rational_arithmetic_unit_assert.svh"

module rau_checker import rau_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [2:0]                    req_action,
   input logic signed [FIELD_WIDTH-1:0] req_operand_den,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [FIELD_WIDTH-1:0] rsp_result_num,
   input logic signed [FIELD_WIDTH-1:0] rsp_result_den,
   input logic                          rsp_equal_flag,
   input logic [1:0]                    rsp_status
);

   logic                     zero_den_accept;
   logic                     zero_den_result;
   logic [2*FIELD_WIDTH+2:0] rsp_payload;

   assign zero_den_accept = req_valid && !req_stall && req_operand_den == '0 &&
                            req_action <= ACT_CMP;
   assign zero_den_result = rsp_valid && rsp_status == STAT_ZERO_DEN && !rsp_equal_flag;
   assign rsp_payload     = {rsp_result_num, rsp_result_den, rsp_equal_flag, rsp_status};

   // busy from accept until the result transaction completes
   `RAU_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `RAU_ASSERT_NOW(a_no_accept_while_pending, rsp_valid, req_stall)
   // zero denominator is rejected on the next cycle
   `RAU_ASSERT_NEXT(a_zero_den_reject, zero_den_accept, zero_den_result)
   `RAU_ASSERT_NOW(a_flag_only_when_ok, rsp_valid && rsp_status != STAT_OK, !rsp_equal_flag)
   `RAU_ASSERT_NEXT(a_result_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind rational_arithmetic_unit rau_checker u_checker (.*);

// ----- verif/rational_arithmetic_unit_test.sv -----
module rational_arithmetic_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rau_pkg::*;

   localparam logic [2:0] ACT_RSVD_A = 3'd6;
   localparam logic [2:0] ACT_RSVD_B = 3'd7;
   localparam int RANDOM_ITEMS = 1000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 200;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic signed [FIELD_WIDTH-1:0] num;
      logic signed [FIELD_WIDTH-1:0] den;
      logic                          eq;
      status_type                    status;
   } fraction_result_type;

   class fraction_scoreboard;
      longint acc_num;
      longint acc_den;
      fraction_result_type expected_q[$];
      int errors;

      function new();
         acc_num = 0;
         acc_den = 1;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit in_range(longint v);
         return v >= -(longint'(1) <<< (VALUE_WIDTH - 1)) &&
                v < (longint'(1) <<< (VALUE_WIDTH - 1));
      endfunction

      function longint unsigned abs_of(longint v);
         return v < 0 ? longint'(-v) : v;
      endfunction

      function longint unsigned common_divisor(longint unsigned a, longint unsigned b);
         longint unsigned t;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a;
      endfunction

      // reduce by gcd, keep state on overflow
      function status_type settle(longint n, longint d);
         longint unsigned g;
         if (n != 0) begin
            g = common_divisor(abs_of(n), abs_of(d));
            if (g > 1) begin
               n = n / longint'(g);
               d = d / longint'(g);
            end
         end
         if (!in_range(n) || !in_range(d))
            return STAT_OVERFLOW;
         acc_num = n;
         acc_den = d;
         return STAT_OK;
      endfunction

      function void note_request(logic [2:0] act, logic signed [FIELD_WIDTH-1:0] n_in,
                                 logic signed [FIELD_WIDTH-1:0] d_in);
         longint on;
         longint od;
         longint an;
         longint ad;
         fraction_result_type r;
         on = n_in;
         od = d_in;
         an = acc_num;
         ad = acc_den;
         r.eq = 1'b0;
         r.status = STAT_OK;
         if (act <= ACT_CMP) begin
            if (od == 0) begin
               r.status = STAT_ZERO_DEN;
            end else begin
               case (act)
                  ACT_LOAD: begin
                     if (in_range(on) && in_range(od)) begin
                        acc_num = on;
                        acc_den = od;
                     end else begin
                        r.status = STAT_OVERFLOW;
                     end
                  end
                  ACT_ADD: r.status = settle(an * od + on * ad, ad * od);
                  ACT_SUB: r.status = settle(an * od - on * ad, ad * od);
                  ACT_MUL: r.status = settle(an * on, ad * od);
                  ACT_DIV: begin
                     if (on == 0)
                        r.status = STAT_DIV_ZERO;
                     else
                        r.status = settle(an * od, ad * on);
                  end
                  ACT_CMP: r.eq = (an * od == on * ad);
                  default: ;
               endcase
            end
         end
         r.num = acc_num[FIELD_WIDTH-1:0];
         r.den = acc_den[FIELD_WIDTH-1:0];
         expected_q.push_back(r);
      endfunction

      function void check_response(logic signed [FIELD_WIDTH-1:0] num,
                                   logic signed [FIELD_WIDTH-1:0] den,
                                   logic eq, logic [1:0] status);
         fraction_result_type r;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transaction num %0d den %0d eq %0d status %0d",
                     $time, num, den, eq, status);
            errors++;
            return;
         end
         r = expected_q.pop_front();
         if (num !== r.num) begin
            $display("%0t: result_num expected %0d, actual %0d", $time, r.num, num);
            errors++;
         end
         if (den !== r.den) begin
            $display("%0t: result_den expected %0d, actual %0d", $time, r.den, den);
            errors++;
         end
         if (eq !== r.eq) begin
            $display("%0t: equal_flag expected %0d, actual %0d", $time, r.eq, eq);
            errors++;
         end
         if (status !== r.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, r.status, status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_action = ACT_LOAD;
   logic signed [FIELD_WIDTH-1:0] req_operand_num = '0;
   logic signed [FIELD_WIDTH-1:0] req_operand_den = 16'sd1;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [FIELD_WIDTH-1:0] rsp_result_num;
   logic signed [FIELD_WIDTH-1:0] rsp_result_den;
   logic rsp_equal_flag;
   logic [1:0] rsp_status;

   fraction_scoreboard sb = new();
   bit quiet = 1'b0;
   bit hold_long = 1'b0;
   int unsigned idle_cycles = 0;

   rational_arithmetic_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_operand_num(req_operand_num),
      .req_operand_den(req_operand_den),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_num(rsp_result_num),
      .rsp_result_den(rsp_result_den),
      .rsp_equal_flag(rsp_equal_flag),
      .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_item(input logic [2:0] act, input logic signed [FIELD_WIDTH-1:0] n,
                            input logic signed [FIELD_WIDTH-1:0] d);
      req_valid <= 1'b1;
      req_action <= act;
      req_operand_num <= n;
      req_operand_den <= d;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_request(act, n, d);
   endtask

   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13))
            @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   function automatic logic signed [FIELD_WIDTH-1:0] pick_value();
      logic signed [FIELD_WIDTH-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = FIELD_WIDTH'($urandom);
         3: begin
            case ($urandom_range(0, 4))
               0: v = 16'sh8000;
               1: v = 16'sh7fff;
               2: v = -16'sd1;
               3: v = 16'sd0;
               default: v = 16'sd1;
            endcase
         end
         default: v = FIELD_WIDTH'($urandom_range(0, 40) - 20);
      endcase
      return v;
   endfunction

   task automatic send_random_item();
      logic [2:0] act;
      logic signed [FIELD_WIDTH-1:0] n;
      logic signed [FIELD_WIDTH-1:0] d;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) act = ACT_LOAD;
      else if (roll < 30) act = ACT_ADD;
      else if (roll < 45) act = ACT_SUB;
      else if (roll < 60) act = ACT_MUL;
      else if (roll < 75) act = ACT_DIV;
      else if (roll < 95) act = ACT_CMP;
      else if (roll < 97) act = ACT_RSVD_A;
      else act = ACT_RSVD_B;
      n = pick_value();
      d = pick_value();
      // compare against the accumulator itself, possibly with both signs flipped
      if (act == ACT_CMP && $urandom_range(0, 1) == 1) begin
         n = sb.acc_num[FIELD_WIDTH-1:0];
         d = sb.acc_den[FIELD_WIDTH-1:0];
         if ($urandom_range(0, 1) == 1) begin
            n = -n;
            d = -d;
         end
      end
      send_item(act, n, d);
   endtask

   // receiver stall bursts
   initial begin
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES)
               @(posedge clock);
            hold_long = 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13))
               @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 25))
               @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_result_num, rsp_result_den, rsp_equal_flag, rsp_status);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (8)
         @(posedge clock);
      reset <= 1'b0;

      send_item(ACT_CMP, 16'sd0, 16'sd1);
      send_item(ACT_LOAD, 16'sd5, 16'sd0);
      send_item(ACT_LOAD, 16'sh7fff, 16'sh8000);
      send_item(ACT_LOAD, 16'sh8000, 16'sh7fff);
      send_item(ACT_CMP, 16'sh8000, 16'sh7fff);
      send_item(ACT_CMP, 16'sd1, 16'sd0);
      send_item(ACT_MUL, 16'sh7fff, 16'sd1);
      send_item(ACT_LOAD, 16'sd3, 16'sd4);
      send_item(ACT_ADD, 16'sd1, 16'sd4);
      send_item(ACT_SUB, 16'sd5, 16'sd6);
      send_item(ACT_MUL, -16'sd2, 16'sd3);
      send_item(ACT_DIV, 16'sd0, 16'sd5);
      send_item(ACT_DIV, 16'sd7, 16'sd0);
      send_item(ACT_DIV, -16'sd3, 16'sd7);
      send_item(ACT_RSVD_A, 16'sh7fff, 16'sd0);
      send_item(ACT_RSVD_B, 16'sh8000, -16'sd1);
      send_item(ACT_LOAD, 16'sd0, 16'sd5);
      send_item(ACT_ADD, 16'sd0, 16'sd7);
      send_item(ACT_LOAD, 16'sh7fff, 16'sd1);
      send_item(ACT_ADD, 16'sh7fff, 16'sd1);
      send_item(ACT_LOAD, 16'sd1, -16'sd2);
      send_item(ACT_ADD, 16'sd1, -16'sd3);
      send_item(ACT_LOAD, 16'sh8000, -16'sd1);
      send_item(ACT_DIV, -16'sd1, 16'sh7fff);
      send_item(ACT_CMP, 16'sd1, -16'sd6);
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 300)
            hold_long = 1'b1;
         if (i == 600)
            drain_results();
         if (i == RANDOM_ITEMS - 150)
            quiet = 1'b1;
         send_random_item();
         if (i != 300 && !(i > 300 && hold_long))
            sender_gap();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
